// ===== rtl/core/lcmlt_pkg.sv =====
// Shared types and constants for the max line tree.
package lcmlt_pkg;

	localparam int NODE_W = 17;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic signed [63:0] MOST_NEG = {1'b1, 63'b0};

	typedef struct packed {
		logic               cmd;
		logic signed [31:0] slope;
		logic signed [31:0] intercept;
		logic signed [31:0] position;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] best_value;
		logic [1:0]         status;
	} out_item_t;

	typedef struct packed {
		logic               valid;
		logic signed [31:0] slope;
		logic signed [31:0] icpt;
	} entry_t;

	// Walk state handed from one level to the next.
	typedef struct packed {
		logic               active;
		logic               cmd;
		logic signed [31:0] slope;
		logic signed [31:0] icpt;
		logic signed [31:0] x;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic [NODE_W-1:0]  node;
		logic signed [63:0] best;
		logic               found;
	} walk_t;

endpackage

// ===== rtl/core/lcmlt_cell.sv =====
// One tree level: node store for this level plus the insert/query step.
module lcmlt_cell #(
	parameter int LVL    = 0,
	parameter int X_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_v,
	input  lcmlt_pkg::walk_t      in_tok,
	output logic                  out_v,
	output lcmlt_pkg::walk_t      out_tok,
	input  logic                  clr_en,
	input  logic [X_BITS-1:0]     clr_addr
);

	localparam int AW = (LVL == 0) ? 1 : LVL;
	localparam int DEPTH = 1 << AW;
	localparam logic [AW-1:0] AMASK = AW'((1 << LVL) - 1);

	lcmlt_pkg::entry_t mem [DEPTH];
	lcmlt_pkg::entry_t rd_q;
	lcmlt_pkg::walk_t  tok_q;
	lcmlt_pkg::walk_t  nxt;
	lcmlt_pkg::entry_t wr_data;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic              wr_en, wr_node;
	logic              ph1_q, ph2_q, ph3_q, out_v_q;
	logic signed [31:0] mid_q;
	logic signed [32:0] diff, mid33;
	logic signed [31:0] xs;
	logic signed [63:0] pc_lo_q, pn_lo_q, pc_hi_q, pn_hi_q, pc_mid_q, pn_mid_q;
	logic signed [63:0] vc_lo_q, vn_lo_q, vc_hi_q, vn_hi_q, vc_mid_q, vn_mid_q;
	logic signed [63:0] cb64, nb64;
	logic               c_keep, c_repl, swap, go_left;
	lcmlt_pkg::walk_t   out_q;

	assign rd_addr = in_tok.node[AW-1:0] & AMASK;
	assign diff    = {in_tok.hi[31], in_tok.hi} - {in_tok.lo[31], in_tok.lo};
	assign mid33   = {in_tok.lo[31], in_tok.lo} + (diff >>> 1);
	assign xs      = (tok_q.cmd == lcmlt_pkg::CMD_QUERY) ? tok_q.x : tok_q.lo;
	assign cb64    = {{32{rd_q.icpt[31]}}, rd_q.icpt};
	assign nb64    = {{32{tok_q.icpt[31]}}, tok_q.icpt};

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (in_v) begin
			rd_q  <= mem[rd_addr];
			tok_q <= in_tok;
			mid_q <= mid33[31:0];
		end
		if (ph1_q) begin
			pc_lo_q  <= rd_q.slope * xs;
			pn_lo_q  <= tok_q.slope * xs;
			pc_hi_q  <= rd_q.slope * tok_q.hi;
			pn_hi_q  <= tok_q.slope * tok_q.hi;
			pc_mid_q <= rd_q.slope * mid_q;
			pn_mid_q <= tok_q.slope * mid_q;
		end
		if (ph2_q) begin
			vc_lo_q  <= pc_lo_q + cb64;
			vn_lo_q  <= pn_lo_q + nb64;
			vc_hi_q  <= pc_hi_q + cb64;
			vn_hi_q  <= pn_hi_q + nb64;
			vc_mid_q <= pc_mid_q + cb64;
			vn_mid_q <= pn_mid_q + nb64;
		end
		if (ph3_q)
			out_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph1_q   <= 1'b0;
			ph2_q   <= 1'b0;
			ph3_q   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			ph1_q   <= in_v;
			ph2_q   <= ph1_q;
			ph3_q   <= ph2_q;
			out_v_q <= ph3_q;
		end
	end

	// Take a query's best, or keep, replace, or swap and push loser down.
	always_comb begin
		nxt     = tok_q;
		wr_node = 1'b0;
		c_keep  = (vc_lo_q >= vn_lo_q) && (vc_hi_q >= vn_hi_q);
		c_repl  = (vc_lo_q <= vn_lo_q) && (vc_hi_q <= vn_hi_q);
		swap    = vc_mid_q < vn_mid_q;
		go_left = 1'b0;
		if (tok_q.active) begin
			if (!rd_q.valid) begin
				nxt.active = 1'b0;
				wr_node    = (tok_q.cmd == lcmlt_pkg::CMD_INSERT);
			end else if (tok_q.cmd == lcmlt_pkg::CMD_QUERY) begin
				if (!tok_q.found || vc_lo_q > tok_q.best)
					nxt.best = vc_lo_q;
				nxt.found = 1'b1;
				if (tok_q.lo >= tok_q.hi)
					nxt.active = 1'b0;
				else
					go_left = tok_q.x <= mid_q;
			end else if (c_keep) begin
				nxt.active = 1'b0;
			end else if (c_repl) begin
				nxt.active = 1'b0;
				wr_node    = 1'b1;
			end else begin
				wr_node = swap;
				if (swap) begin
					nxt.slope = rd_q.slope;
					nxt.icpt  = rd_q.icpt;
					go_left   = vn_lo_q <= vc_lo_q;
				end else begin
					go_left   = vc_lo_q <= vn_lo_q;
				end
			end
			if (nxt.active) begin
				if (go_left)
					nxt.hi = mid_q;
				else
					nxt.lo = mid_q + 32'sd1;
				nxt.node = {tok_q.node[lcmlt_pkg::NODE_W-2:0], ~go_left};
			end
		end
	end

	always_comb begin
		wr_en   = clr_en || (ph3_q && wr_node);
		wr_addr = clr_en ? (clr_addr[AW-1:0] & AMASK) : (tok_q.node[AW-1:0] & AMASK);
		wr_data = '0;
		if (!clr_en) begin
			wr_data.valid = 1'b1;
			wr_data.slope = tok_q.slope;
			wr_data.icpt  = tok_q.icpt;
		end
	end

	assign out_v   = out_v_q;
	assign out_tok = out_q;

endmodule

// ===== rtl/core/li_chao_max_line_tree.sv =====
// Top level: range registers, item control and the chain of level cells.
//
//  channel  | signals                         | direction
//  ---------+---------------------------------+----------
//  input    | in_valid, in_stall, in_data     | in
//  result   | out_valid, out_stall, out_data  | out
//  config   | cfg_we, cfg_index, cfg_data     | in
//
// One item at a time walks the cells, one cell per tree level; each cell works
// in steps (node read, six parallel multiplies, intercept adds, decision).
// Out-of-range queries and inserts into an empty range skip the walk. After
// reset a clearing pass empties the node stores; no item is taken meanwhile.
// A query result waits in the output register while the next item is taken.
module li_chao_max_line_tree #(
	parameter int X_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  lcmlt_pkg::in_item_t   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output lcmlt_pkg::out_item_t  out_data,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [31:0]           cfg_data
);

	localparam logic REG_LOW  = 1'b0;
	localparam logic REG_HIGH = 1'b1;

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_CHECK, S_WALK, S_HOLD} state_t;

	state_t                state_q;
	logic [X_BITS-1:0]     clr_cnt_q;
	logic signed [31:0]    range_low_q, range_high_q;
	lcmlt_pkg::in_item_t   item_q;
	lcmlt_pkg::out_item_t  res_q, out_q;
	logic                  out_valid_q;
	logic                  launch_q;
	lcmlt_pkg::walk_t      launch_tok_q;
	logic signed [32:0]    cap, hi33;
	logic signed [31:0]    eff_hi;
	logic                  empty, outside;
	logic                  walk_go;

	logic                  v_w   [X_BITS+2];
	lcmlt_pkg::walk_t      tok_w [X_BITS+2];

	assign cap     = {range_low_q[31], range_low_q} + 33'sd1 * ((33'sd1 <<< X_BITS) - 33'sd1);
	assign hi33    = {range_high_q[31], range_high_q};
	assign eff_hi  = (hi33 > cap) ? cap[31:0] : range_high_q;
	assign empty   = range_high_q < range_low_q;
	assign outside = (item_q.position < range_low_q) || (item_q.position > eff_hi);
	assign walk_go = (state_q == S_CHECK) && !empty
		&& ((item_q.cmd == lcmlt_pkg::CMD_INSERT) || !outside);

	assign v_w[0]   = launch_q;
	assign tok_w[0] = launch_tok_q;

	for (genvar g = 0; g <= X_BITS; g++) begin : g_lvl
		lcmlt_cell #(.LVL(g), .X_BITS(X_BITS)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_v     (v_w[g]),
			.in_tok   (tok_w[g]),
			.out_v    (v_w[g+1]),
			.out_tok  (tok_w[g+1]),
			.clr_en   (state_q == S_CLEAR),
			.clr_addr (clr_cnt_q)
		);
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_q <= in_data;
		if (state_q == S_CHECK) begin
			launch_tok_q.active <= 1'b1;
			launch_tok_q.cmd    <= item_q.cmd;
			launch_tok_q.slope  <= item_q.slope;
			launch_tok_q.icpt   <= item_q.intercept;
			launch_tok_q.x      <= item_q.position;
			launch_tok_q.lo     <= range_low_q;
			launch_tok_q.hi     <= eff_hi;
			launch_tok_q.node   <= lcmlt_pkg::NODE_W'(1);
			launch_tok_q.best   <= lcmlt_pkg::MOST_NEG;
			launch_tok_q.found  <= 1'b0;
			res_q.best_value    <= lcmlt_pkg::MOST_NEG;
			res_q.status        <= lcmlt_pkg::ST_RANGE;
		end
		if (state_q == S_WALK && v_w[X_BITS+1]) begin
			res_q.best_value <= tok_w[X_BITS+1].found ? tok_w[X_BITS+1].best
				: lcmlt_pkg::MOST_NEG;
			res_q.status     <= tok_w[X_BITS+1].found ? lcmlt_pkg::ST_FOUND
				: lcmlt_pkg::ST_EMPTY;
		end
		if (state_q == S_HOLD && (!out_valid_q || !out_stall))
			out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_cnt_q    <= '0;
			range_low_q  <= 32'sd0;
			range_high_q <= 32'sd1023;
			out_valid_q  <= 1'b0;
			launch_q     <= 1'b0;
		end else begin
			launch_q <= walk_go;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_LOW:  range_low_q  <= cfg_data;
					REG_HIGH: range_high_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_HOLD && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == '1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid)
						state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (item_q.cmd == lcmlt_pkg::CMD_INSERT) begin
						if (empty)
							state_q <= S_IDLE;
						else
							state_q <= S_WALK;
					end else if (empty || outside) begin
						state_q <= S_HOLD;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (v_w[X_BITS+1])
						state_q <= (item_q.cmd == lcmlt_pkg::CMD_QUERY) ? S_HOLD : S_IDLE;
				end
				S_HOLD: begin
					// hold until the output register frees up
					if (!out_valid_q || !out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== test/lcmlt_checker.sv =====
// Result checker for the max line tree: envelope predictor and result compare.
`timescale 1ns / 100ps
module lcmlt_checker #(
	parameter int X_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  lcmlt_pkg::in_item_t   in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  lcmlt_pkg::out_item_t  out_data,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [31:0]           cfg_data,
	output int                    fail_count,
	output int                    pending
);

	localparam int NODES = 1 << (X_BITS + 1);

	logic                 env_valid [NODES];
	logic signed [31:0]   env_slope [NODES];
	logic signed [31:0]   env_icpt  [NODES];
	logic signed [63:0]   span_low, span_high;
	lcmlt_pkg::out_item_t answers [$];

	function automatic logic signed [63:0] line_at(logic signed [63:0] a,
		logic signed [63:0] b, logic signed [63:0] x);
		return a * x + b;
	endfunction

	function automatic bit clip_span(output logic signed [63:0] lo,
		output logic signed [63:0] hi);
		logic signed [63:0] cap;
		cap = span_low + (64'sd1 <<< X_BITS) - 64'sd1;
		lo = span_low;
		hi = (span_high > cap) ? cap : span_high;
		return span_high >= span_low;
	endfunction

	task automatic add_line(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [63:0] lo, hi, mid, ca, cb, t;
		int n;
		n = 1;
		if (!clip_span(lo, hi))
			return;
		forever begin
			n = n & (NODES - 1);
			if (n == 0)
				return;
			if (!env_valid[n]) begin
				env_valid[n] = 1'b1;
				env_slope[n] = a[31:0];
				env_icpt[n] = b[31:0];
				return;
			end
			ca = env_slope[n];
			cb = env_icpt[n];
			if (line_at(ca, cb, lo) >= line_at(a, b, lo) &&
			    line_at(ca, cb, hi) >= line_at(a, b, hi))
				return;
			if (line_at(ca, cb, lo) <= line_at(a, b, lo) &&
			    line_at(ca, cb, hi) <= line_at(a, b, hi)) begin
				env_slope[n] = a[31:0];
				env_icpt[n] = b[31:0];
				return;
			end
			mid = lo + (hi - lo) / 2;
			if (line_at(ca, cb, mid) < line_at(a, b, mid)) begin
				t = ca; ca = a; a = t;
				t = cb; cb = b; b = t;
				env_slope[n] = ca[31:0];
				env_icpt[n] = cb[31:0];
			end
			if (line_at(ca, cb, lo) <= line_at(a, b, lo)) begin
				hi = mid;
				n = 2 * n;
			end else begin
				lo = mid + 1;
				n = 2 * n + 1;
			end
		end
	endtask

	function automatic lcmlt_pkg::out_item_t peak_at(logic signed [63:0] x);
		lcmlt_pkg::out_item_t r;
		logic signed [63:0] lo, hi, mid, v;
		int n;
		bit found;
		n = 1;
		found = 0;
		r.best_value = lcmlt_pkg::MOST_NEG;
		if (!clip_span(lo, hi) || x < lo || x > hi) begin
			r.status = lcmlt_pkg::ST_RANGE;
			return r;
		end
		forever begin
			n = n & (NODES - 1);
			if (n == 0 || !env_valid[n])
				break;
			v = line_at(env_slope[n], env_icpt[n], x);
			if (!found || v > r.best_value)
				r.best_value = v;
			found = 1;
			if (lo >= hi)
				break;
			mid = lo + (hi - lo) / 2;
			if (x <= mid) begin
				hi = mid;
				n = 2 * n;
			end else begin
				lo = mid + 1;
				n = 2 * n + 1;
			end
		end
		r.status = found ? lcmlt_pkg::ST_FOUND : lcmlt_pkg::ST_EMPTY;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lcmlt_pkg::out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++)
				env_valid[i] = 1'b0;
			span_low = 0;
			span_high = 1023;
			answers.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (answers.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %0d status %0d",
							out_data.best_value, out_data.status);
				end else begin
					want = answers.pop_front();
					if (want.best_value !== out_data.best_value ||
					    want.status !== out_data.status) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %0d/%0d got %0d/%0d",
								want.best_value, want.status,
								out_data.best_value, out_data.status);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == 1'b0)
					span_low = $signed(cfg_data);
				else
					span_high = $signed(cfg_data);
			end
			if (in_valid && !in_stall) begin
				if (in_data.cmd == lcmlt_pkg::CMD_INSERT)
					add_line(in_data.slope, in_data.intercept);
				else
					answers.push_back(peak_at(in_data.position));
			end
			pending = answers.size();
		end
	end
endmodule

// ===== test/tb.sv =====
// Testbench top: stimulus, configuration phases and verdict for the max line tree.
`timescale 1ns / 100ps
module tb;

	logic                 clk, arst_n;
	logic                 in_valid, in_stall, out_valid, out_stall;
	lcmlt_pkg::in_item_t  in_data;
	lcmlt_pkg::out_item_t out_data;
	logic                 cfg_we, cfg_index;
	logic [31:0]          cfg_data;
	int                   fail_count, pending;
	bit                   calm;

	li_chao_max_line_tree u_top (.*);
	lcmlt_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Verification failed");
		$finish;
	end

	// receiver stall bursts
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				out_stall <= 0;
			end
		end
	end

	// valid stays high after the transaction unless idling follows
	task automatic send(logic c, logic [31:0] a, logic [31:0] b, logic [31:0] x);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_data <= '{c, a, b, x};
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic set_reg(logic idx, logic [31:0] v);
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [31:0] wild();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 20) - 10;
			default: return $urandom;
		endcase
	endfunction

	task automatic burst(int count, int base, int width);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 1))
				send(lcmlt_pkg::CMD_INSERT,
					$urandom_range(0, 3) ? $urandom_range(0, 2000) - 1000 : wild(),
					$urandom_range(0, 3) ? $urandom : wild(), 0);
			else
				send(lcmlt_pkg::CMD_QUERY, 0, 0, $urandom_range(0, 15) == 0 ? wild()
					: base - 2 + $urandom_range(0, width + 3));
		end
	endtask

	initial begin
		in_valid = 0; in_data = '0;
		cfg_we = 0; cfg_index = 0; cfg_data = 0; calm = 0;
		arst_n = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		// directed: empty tree, extremes, ties
		send(lcmlt_pkg::CMD_QUERY, 0, 0, 5);
		send(lcmlt_pkg::CMD_QUERY, 0, 0, -1);
		send(lcmlt_pkg::CMD_QUERY, 0, 0, 1024);
		send(lcmlt_pkg::CMD_INSERT, 32'h7fff_ffff, 32'h8000_0000, 0);
		send(lcmlt_pkg::CMD_INSERT, 32'h8000_0000, 32'h7fff_ffff, 0);
		send(lcmlt_pkg::CMD_INSERT, 0, 100, 0);
		send(lcmlt_pkg::CMD_INSERT, 0, 100, 0);
		send(lcmlt_pkg::CMD_INSERT, 1, 0, 0);
		send(lcmlt_pkg::CMD_INSERT, -1, 1023, 0);
		send(lcmlt_pkg::CMD_QUERY, 0, 0, 0);
		send(lcmlt_pkg::CMD_QUERY, 0, 0, 1023);
		send(lcmlt_pkg::CMD_QUERY, 0, 0, 512);
		send(lcmlt_pkg::CMD_QUERY, 0, 0, 32'h7fff_ffff);
		send(lcmlt_pkg::CMD_QUERY, 0, 0, 32'h8000_0000);
		burst(300, 0, 1024);
		// extreme low end, over-wide range saturates
		set_reg(0, 32'h8000_0000);
		set_reg(1, 32'h7fff_ffff);
		burst(250, 32'sh8000_0000, 1024);
		// extreme high end
		set_reg(0, 32'h7fff_fc00);
		burst(250, 32'sh7fff_fc00, 1024);
		// empty range
		set_reg(1, 32'h7fff_fb00);
		burst(60, 32'sh7fff_fc00, 64);
		// tiny ranges
		set_reg(0, -3);
		set_reg(1, 4);
		burst(150, -3, 8);
		set_reg(0, 7);
		set_reg(1, 7);
		burst(60, 7, 1);
		set_reg(0, $urandom_range(0, 100) - 50);
		set_reg(1, 32'd300);
		burst(150, -50, 400);
		calm = 1;
		burst(130, -50, 400);
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/lcmlt_pkg.sv
rtl/core/lcmlt_cell.sv
rtl/core/li_chao_max_line_tree.sv
test/lcmlt_checker.sv
test/tb.sv
